/* sv/fat12ccw_pkg.sv */
package fat12ccw_pkg;

    // Defaults for the top-level parameters.
    localparam int TABLE_BYTES_DEF = 8192;
    localparam int MAX_CHAIN_DEF   = 64;

    // Depth of the job queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Command codes of an input beat.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_WALK = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_LOAD  = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_TRUNC = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DATA_START = 2'd0;
    localparam logic [1:0] CFG_SPC        = 2'd1;

    // Job kinds decided by the front.
    localparam logic [1:0] JOB_LOAD = 2'd0;
    localparam logic [1:0] JOB_WALK = 2'd1;
    localparam logic [1:0] JOB_BAD  = 2'd2;

    // Cluster values with a fixed meaning.
    localparam logic [11:0] ENTRY_MASK  = 12'hFFF;
    localparam logic [11:0] CHAIN_END   = 12'hFF8;
    localparam logic [11:0] MIN_CLUSTER = 12'd2;

    typedef struct packed {
        logic        command;
        logic [12:0] table_address;
        logic [7:0]  table_byte;
        logic [11:0] start_cluster;
    } t_in_item;

    typedef struct packed {
        logic [11:0] cluster;
        logic [31:0] sector_address;
        logic [1:0]  status;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic        wr_ok;
        logic [12:0] address;
        logic [7:0]  data;
        logic [11:0] cluster;
    } t_job;

endpackage

/* sv/fat12ccw_front.sv */
module fat12ccw_front #(
    parameter int TABLE_BYTES = fat12ccw_pkg::TABLE_BYTES_DEF
) (
    input  logic                   i_start,
    input  fat12ccw_pkg::t_in_item i_item,
    input  logic                   i_full,
    output logic                   o_busy,
    output logic                   o_push,
    output fat12ccw_pkg::t_job     o_job
);

    // A beat is taken whenever the queue has room.
    assign o_busy = i_full;
    assign o_push = i_start && !i_full;

    // Classify the beat: loads carry their range check, walks that start
    // on a reserved cluster are marked bad right away.
    always_comb begin
        o_job.address = i_item.table_address;
        o_job.data    = i_item.table_byte;
        o_job.cluster = i_item.start_cluster & fat12ccw_pkg::ENTRY_MASK;
        o_job.wr_ok   = ({1'b0, i_item.table_address} < 14'(TABLE_BYTES));
        if (i_item.command == fat12ccw_pkg::CMD_WALK) begin
            if (i_item.start_cluster < fat12ccw_pkg::MIN_CLUSTER) begin
                o_job.kind = fat12ccw_pkg::JOB_BAD;
            end else begin
                o_job.kind = fat12ccw_pkg::JOB_WALK;
            end
        end else begin
            o_job.kind = fat12ccw_pkg::JOB_LOAD;
        end
    end

endmodule

/* sv/fat12ccw_fifo.sv */
module fat12ccw_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  fat12ccw_pkg::t_job i_data,
    input  logic               i_pop,
    output logic               o_valid,
    output logic               o_full,
    output fat12ccw_pkg::t_job o_data
);

    localparam int DEPTH = fat12ccw_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    fat12ccw_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [PW-1:0] n_wr_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* sv/fat12ccw_table.sv */
module fat12ccw_table #(
    parameter int TABLE_BYTES = fat12ccw_pkg::TABLE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_wr_en,
    input  logic [12:0] i_wr_addr,
    input  logic [7:0]  i_wr_data,
    input  logic        i_rd_en,
    input  logic [12:0] i_rd_addr,
    output logic [15:0] o_word
);

    // Two banks of even and odd bytes, so both bytes of an entry come out
    // of a single read.
    localparam int BANK_DEPTH = (TABLE_BYTES + 1) / 2;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);

    logic [7:0] r_even [BANK_DEPTH];
    logic [7:0] r_odd  [BANK_DEPTH];

    logic [13:0] even_addr, odd_addr;
    logic        even_ok, odd_ok;
    logic [7:0]  r_even_q, r_odd_q;
    logic        r_even_ok, r_odd_ok, r_lo_odd;
    logic [7:0]  even_byte, odd_byte;

    // The low byte sits at the read address, the high byte one above it.
    assign even_addr = i_rd_addr[0] ? ({1'b0, i_rd_addr} + 14'd1) : {1'b0, i_rd_addr};
    assign odd_addr  = i_rd_addr[0] ? {1'b0, i_rd_addr} : ({1'b0, i_rd_addr} + 14'd1);
    assign even_ok   = (even_addr < 14'(TABLE_BYTES));
    assign odd_ok    = (odd_addr < 14'(TABLE_BYTES));

    always_ff @(posedge i_clk) begin
        if (i_wr_en && !i_wr_addr[0]) begin
            r_even[i_wr_addr[BANK_AW:1]] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_even_q  <= r_even[even_addr[BANK_AW:1]];
            r_even_ok <= even_ok;
            r_lo_odd  <= i_rd_addr[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_wr_addr[0]) begin
            r_odd[i_wr_addr[BANK_AW:1]] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_odd_q  <= r_odd[odd_addr[BANK_AW:1]];
            r_odd_ok <= odd_ok;
        end
    end

    // Bytes beyond the table read as zero; put them back in byte order.
    assign even_byte = r_even_ok ? r_even_q : 8'd0;
    assign odd_byte  = r_odd_ok ? r_odd_q : 8'd0;
    assign o_word    = r_lo_odd ? {even_byte, odd_byte} : {odd_byte, even_byte};

endmodule

/* sv/fat12ccw_back.sv */
module fat12ccw_back #(
    parameter int TABLE_BYTES = fat12ccw_pkg::TABLE_BYTES_DEF,
    parameter int MAX_CHAIN   = fat12ccw_pkg::MAX_CHAIN_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_job_valid,
    input  fat12ccw_pkg::t_job      i_job,
    output logic                    o_job_pop,
    input  logic [31:0]             i_data_start_lba,
    input  logic [7:0]              i_sectors_per_cluster,
    output logic                    o_strobe,
    output fat12ccw_pkg::t_out_item o_result
);

    localparam int KW = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_EVAL  = 2'd2;

    logic [1:0]  r_state, n_state;
    logic [11:0] r_cl, n_cl;
    logic [KW-1:0] r_k, n_k;
    logic        r_strobe, n_strobe;
    fat12ccw_pkg::t_out_item r_out, n_out;
    logic [19:0] r_prod, n_prod;

    logic        wr_en, rd_en;
    logic [13:0] cl_x3;
    logic [12:0] entry_addr;
    logic [15:0] word;
    logic [11:0] nxt;
    logic [11:0] cl_off;

    // Byte address of the entry: cluster * 3 / 2.
    assign cl_x3      = {2'b00, r_cl} + {1'b0, r_cl, 1'b0};
    assign entry_addr = cl_x3[13:1];

    fat12ccw_table #(
        .TABLE_BYTES(TABLE_BYTES)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(i_job.address),
        .i_wr_data(i_job.data),
        .i_rd_en  (rd_en),
        .i_rd_addr(entry_addr),
        .o_word   (word)
    );

    // Even clusters take the low 12 bits, odd clusters the high 12.
    assign nxt = r_cl[0] ? word[15:4] : word[11:0];

    // Cluster offset product, registered before the add.
    assign cl_off = r_cl - fat12ccw_pkg::MIN_CLUSTER;
    assign n_prod = {8'd0, cl_off} * {12'd0, i_sectors_per_cluster};

    // Walk sequencer: one queue entry at a time, a table read then an evaluation per cluster.
    always_comb begin
        n_state   = r_state;
        n_cl      = r_cl;
        n_k       = r_k;
        n_strobe  = 1'b0;
        n_out     = r_out;
        o_job_pop = 1'b0;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    case (i_job.kind)
                        fat12ccw_pkg::JOB_LOAD: begin
                            wr_en                = i_job.wr_ok;
                            n_strobe             = 1'b1;
                            n_out.cluster        = 12'd0;
                            n_out.sector_address = 32'd0;
                            n_out.status         = fat12ccw_pkg::ST_LOAD;
                            n_out.last           = 1'b1;
                        end
                        fat12ccw_pkg::JOB_BAD: begin
                            n_strobe             = 1'b1;
                            n_out.cluster        = i_job.cluster;
                            n_out.sector_address = 32'd0;
                            n_out.status         = fat12ccw_pkg::ST_BAD;
                            n_out.last           = 1'b1;
                        end
                        fat12ccw_pkg::JOB_WALK: begin
                            n_cl    = i_job.cluster;
                            n_k     = '0;
                            n_state = S_CHECK;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                if (r_cl < fat12ccw_pkg::MIN_CLUSTER) begin
                    n_strobe             = 1'b1;
                    n_out.cluster        = r_cl;
                    n_out.sector_address = 32'd0;
                    n_out.status         = fat12ccw_pkg::ST_BAD;
                    n_out.last           = 1'b1;
                    n_state              = S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_strobe             = 1'b1;
                n_out.cluster        = r_cl;
                n_out.sector_address = i_data_start_lba + {12'd0, r_prod};
                if (nxt >= fat12ccw_pkg::CHAIN_END) begin
                    n_out.status = fat12ccw_pkg::ST_OK;
                    n_out.last   = 1'b1;
                    n_state      = S_IDLE;
                end else if (r_k == KW'(MAX_CHAIN - 1)) begin
                    n_out.status = fat12ccw_pkg::ST_TRUNC;
                    n_out.last   = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_out.status = fat12ccw_pkg::ST_OK;
                    n_out.last   = 1'b0;
                    n_cl         = nxt;
                    n_k          = r_k + 1'b1;
                    n_state      = S_CHECK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge i_clk) begin
        r_cl   <= n_cl;
        r_k    <= n_k;
        r_out  <= n_out;
        r_prod <= n_prod;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

/* sv/fat12_cluster_chain_walker.sv */
// FAT12 cluster chain walker. A beat is taken when i_start is high and o_busy
// is low; beats go into a two-entry job queue, so up to two may be taken while
// earlier work is still running. A load beat writes one allocation table byte
// and gives one load-done result in the cycle after it leaves the queue. A walk
// beat gives one result per cluster of the chain: it leaves the queue, then
// each cluster takes a table read of both entry bytes from the even/odd byte
// banks with the offset multiply, then the evaluation. A walk that reaches a
// cluster below 2 ends with a bad-cluster result, which follows the previous
// result with no gap. Each result stands on o_result for exactly one cycle
// with o_strobe high and cannot be held off; the last result of a beat has
// last set. Table bytes never loaded read back as unknown; configuration must
// be written only while the block is idle, which the block does not enforce.
module fat12_cluster_chain_walker #(
    parameter int TABLE_BYTES = fat12ccw_pkg::TABLE_BYTES_DEF,
    parameter int MAX_CHAIN   = fat12ccw_pkg::MAX_CHAIN_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  fat12ccw_pkg::t_in_item  i_item,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_index,
    input  logic [31:0]             i_cfg_data,
    output logic                    o_strobe,
    output fat12ccw_pkg::t_out_item o_result
);

    logic               push, full, job_valid, job_pop;
    fat12ccw_pkg::t_job push_job, head_job;
    logic [31:0]        r_data_start_lba;
    logic [7:0]         r_sectors_per_cluster;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_start_lba      <= 32'd33;
            r_sectors_per_cluster <= 8'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fat12ccw_pkg::CFG_DATA_START: r_data_start_lba <= i_cfg_data;
                fat12ccw_pkg::CFG_SPC:        r_sectors_per_cluster <= i_cfg_data[7:0];
                default: begin
                    r_data_start_lba <= r_data_start_lba;
                end
            endcase
        end
    end

    fat12ccw_front #(
        .TABLE_BYTES(TABLE_BYTES)
    ) u_front (
        .i_start(i_start),
        .i_item (i_item),
        .i_full (full),
        .o_busy (o_busy),
        .o_push (push),
        .o_job  (push_job)
    );

    fat12ccw_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (push_job),
        .i_pop  (job_pop),
        .o_valid(job_valid),
        .o_full (full),
        .o_data (head_job)
    );

    fat12ccw_back #(
        .TABLE_BYTES(TABLE_BYTES),
        .MAX_CHAIN  (MAX_CHAIN)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_job_valid          (job_valid),
        .i_job                (head_job),
        .o_job_pop            (job_pop),
        .i_data_start_lba     (r_data_start_lba),
        .i_sectors_per_cluster(r_sectors_per_cluster),
        .o_strobe             (o_strobe),
        .o_result             (o_result)
    );

`ifndef SYNTHESIS
    // A chain step passes through a check state and an evaluation state, so a
    // result that is not the last one is followed in the next cycle only by the
    // bad-cluster result of a reached cluster below 2.
    a_step_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |=>
        !o_strobe || (o_result.status == fat12ccw_pkg::ST_BAD))
        else $error("result strobed right after a non-final chain result");

    // A load-done result is a single final beat with empty cluster fields.
    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.status == fat12ccw_pkg::ST_LOAD) |->
        o_result.last && (o_result.cluster == 12'd0) && (o_result.sector_address == 32'd0))
        else $error("malformed load-done result");

    // A bad cluster ends the walk and carries a reserved cluster number.
    a_bad_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result.status == fat12ccw_pkg::ST_BAD) |->
        o_result.last && (o_result.cluster < fat12ccw_pkg::MIN_CLUSTER) &&
        (o_result.sector_address == 32'd0))
        else $error("malformed bad-cluster result");

    // The queue only fills up after a beat was taken.
    a_busy_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(push))
        else $error("busy rose without an accepted beat");
`endif

endmodule

/* test/tb_fat12_cluster_chain_walker.sv */
`timescale 1ns / 100ps

module tb_fat12_cluster_chain_walker;

    localparam int TBL_BYTES    = fat12ccw_pkg::TABLE_BYTES_DEF;
    localparam int CHAIN_LIMIT  = fat12ccw_pkg::MAX_CHAIN_DEF;
    // Sized for a full-length walk of MAX_CHAIN clusters; leave some margin.
    localparam int WALK_LATENCY = 2 * fat12ccw_pkg::MAX_CHAIN_DEF + 12;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int PHASE_BEATS  = 72;
    localparam int MAX_LINKS    = 8;

    typedef struct packed {
        fat12ccw_pkg::t_in_item  item;
        logic                    typed;
        fat12ccw_pkg::t_out_item want;
    } t_dir_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_start;
    logic                    o_busy;
    fat12ccw_pkg::t_in_item  i_item;
    logic                    i_cfg_we;
    logic [1:0]              i_cfg_index;
    logic [31:0]             i_cfg_data;
    logic                    o_strobe;
    fat12ccw_pkg::t_out_item o_result;

    // Shadow of the allocation table and of the configuration registers.
    logic [7:0]  fat_image  [TBL_BYTES];
    bit          fat_loaded [TBL_BYTES];
    logic [31:0] data_start;
    logic [7:0]  spc;

    fat12ccw_pkg::t_out_item pending_results[$];
    fat12ccw_pkg::t_out_item step_results[$];
    logic [11:0]             chain_heads[$];
    t_dir_row                dir_rows[$];
    int                      error_count;
    int                      beats_sent;
    int                      sender_idle_pct;

    fat12_cluster_chain_walker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    always #5 i_clk = ~i_clk;

    // Byte offset of the 12-bit entry of a cluster.
    function automatic int fat_index(input logic [11:0] clus);
        return (int'(clus) * 3) / 2;
    endfunction

    // A byte beyond the table reads as zero.
    function automatic logic [7:0] fat_byte(input int addr);
        if (addr >= TBL_BYTES) return 8'h00;
        return fat_image[addr];
    endfunction

    // Even clusters take the low 12 bits of the word, odd ones the high 12 bits.
    function automatic logic [11:0] fat_entry(input logic [11:0] clus);
        int          idx;
        logic [15:0] word;
        idx  = fat_index(clus);
        word = {fat_byte(idx + 1), fat_byte(idx)};
        return clus[0] ? word[15:4] : word[11:0];
    endfunction

    // True when a walk from this cluster only reads bytes that were loaded.
    function automatic bit walk_is_defined(input logic [11:0] start_clus);
        logic [11:0] clus;
        int          idx;
        int          k;
        clus = start_clus;
        for (k = 0; k < CHAIN_LIMIT; k++) begin
            if (clus < fat12ccw_pkg::MIN_CLUSTER) return 1'b1;
            idx = fat_index(clus);
            if (!fat_loaded[idx] || !fat_loaded[idx + 1]) return 1'b0;
            if (fat_entry(clus) >= fat12ccw_pkg::CHAIN_END) return 1'b1;
            clus = fat_entry(clus);
        end
        return 1'b1;
    endfunction

    // Apply one accepted beat to the shadow state and list the results it gives.
    function automatic void predict_fat_walk(input fat12ccw_pkg::t_in_item it);
        logic [11:0] clus;
        logic [11:0] nxt;
        logic [31:0] sector;
        int          k;
        step_results.delete();
        if (it.command == fat12ccw_pkg::CMD_LOAD) begin
            if (int'(it.table_address) < TBL_BYTES) begin
                fat_image[it.table_address]  = it.table_byte;
                fat_loaded[it.table_address] = 1'b1;
            end
            step_results.push_back(fat12ccw_pkg::t_out_item'{12'd0, 32'd0,
                                   fat12ccw_pkg::ST_LOAD, 1'b1});
            return;
        end
        clus = it.start_cluster;
        for (k = 0; k < CHAIN_LIMIT; k++) begin
            if (clus < fat12ccw_pkg::MIN_CLUSTER) begin
                step_results.push_back(fat12ccw_pkg::t_out_item'{clus, 32'd0,
                                       fat12ccw_pkg::ST_BAD, 1'b1});
                return;
            end
            sector = data_start + (32'(clus) - 32'd2) * 32'(spc);
            nxt    = fat_entry(clus);
            if (nxt >= fat12ccw_pkg::CHAIN_END) begin
                step_results.push_back(fat12ccw_pkg::t_out_item'{clus, sector,
                                       fat12ccw_pkg::ST_OK, 1'b1});
                return;
            end
            if (k == CHAIN_LIMIT - 1) begin
                step_results.push_back(fat12ccw_pkg::t_out_item'{clus, sector,
                                       fat12ccw_pkg::ST_TRUNC, 1'b1});
                return;
            end
            step_results.push_back(fat12ccw_pkg::t_out_item'{clus, sector,
                                   fat12ccw_pkg::ST_OK, 1'b0});
            clus = nxt;
        end
    endfunction

    // Beat builders; the fields a command ignores get random values.
    function automatic fat12ccw_pkg::t_in_item load_beat(input int addr,
                                                         input logic [7:0] value);
        fat12ccw_pkg::t_in_item it;
        it.command       = fat12ccw_pkg::CMD_LOAD;
        it.table_address = 13'(addr);
        it.table_byte    = value;
        it.start_cluster = 12'($urandom);
        return it;
    endfunction

    function automatic fat12ccw_pkg::t_in_item walk_beat(input logic [11:0] clus);
        fat12ccw_pkg::t_in_item it;
        it.command       = fat12ccw_pkg::CMD_WALK;
        it.table_address = 13'($urandom);
        it.table_byte    = 8'($urandom);
        it.start_cluster = clus;
        return it;
    endfunction

    function automatic t_dir_row dir_load(input int addr, input logic [7:0] value);
        return t_dir_row'{load_beat(addr, value), 1'b1,
                          fat12ccw_pkg::t_out_item'{12'd0, 32'd0,
                                                    fat12ccw_pkg::ST_LOAD, 1'b1}};
    endfunction

    function automatic t_dir_row dir_walk(input logic [11:0] clus);
        return t_dir_row'{walk_beat(clus), 1'b0, fat12ccw_pkg::t_out_item'('0)};
    endfunction

    function automatic t_dir_row dir_walk_exp(input logic [11:0] clus,
                                              input logic [31:0] sector,
                                              input logic [1:0] status);
        return t_dir_row'{walk_beat(clus), 1'b1,
                          fat12ccw_pkg::t_out_item'{clus, sector, status, 1'b1}};
    endfunction

    // Offer one beat after a random gap and record what it should produce.
    // A typed row supplies its single expected result directly.
    task automatic send_beat(input fat12ccw_pkg::t_in_item it, input logic typed,
                             input fat12ccw_pkg::t_out_item want);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_start <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_busy);
        predict_fat_walk(it);
        if (typed) begin
            pending_results.push_back(want);
        end else begin
            foreach (step_results[j]) pending_results.push_back(step_results[j]);
        end
        beats_sent++;
    endtask

    task automatic send_noise();
        send_beat(load_beat($urandom_range(TBL_BYTES - 1), 8'($urandom)), 1'b0, '0);
    endtask

    // Write a 12-bit entry as two byte loads, keeping the neighbor's nibble.
    task automatic load_entry(input logic [11:0] clus, input logic [11:0] value);
        int         idx;
        logic [7:0] lo;
        logic [7:0] hi;
        idx = fat_index(clus);
        if (clus[0]) begin
            lo = {value[3:0], fat_image[idx][3:0]};
            hi = value[11:4];
        end else begin
            lo = value[7:0];
            hi = {fat_image[idx + 1][7:4], value[11:8]};
        end
        send_beat(load_beat(idx, lo), 1'b0, '0);
        send_beat(load_beat(idx + 1, hi), 1'b0, '0);
    endtask

    // Lay down a fresh chain of distinct clusters, end it with an end mark, a
    // bad cluster or a loop back into itself, then walk it from one of its links.
    task automatic build_and_walk();
        logic [11:0] links [MAX_LINKS];
        logic [11:0] clus;
        logic [11:0] tail;
        int          len;
        int          pick;
        int          n;
        int          m;
        bit          fresh;
        len = ($urandom_range(9) == 0) ? MAX_LINKS : $urandom_range(1, 4);
        for (n = 0; n < len; n++) begin
            do begin
                if ($urandom_range(9) == 0) clus = 12'hFF0 + 12'($urandom_range(15));
                else clus = 12'($urandom_range(2, 4095));
                fresh = 1'b1;
                for (m = 0; m < n; m++) begin
                    if (links[m] == clus) fresh = 1'b0;
                end
            end while (!fresh);
            links[n] = clus;
        end
        pick = $urandom_range(99);
        if (pick < 50) tail = fat12ccw_pkg::CHAIN_END + 12'($urandom_range(7));
        else if (pick < 70) tail = 12'($urandom_range(1));
        else tail = links[$urandom_range(len - 1)];
        for (n = 0; n < len - 1; n++) load_entry(links[n], links[n + 1]);
        load_entry(links[len - 1], tail);
        clus = ($urandom_range(3) == 0) ? links[$urandom_range(len - 1)] : links[0];
        chain_heads.push_back(clus);
        send_beat(walk_beat(clus), 1'b0, '0);
    endtask

    // Hold off the sender until every expected result has come, then settle.
    task automatic drain_results(input int settle);
        int waited;
        i_start <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            error_count++;
            $display("%0t: %0d expected results never arrived", $time,
                     pending_results.size());
            pending_results.delete();
        end
        repeat (settle) @(posedge i_clk);
    endtask

    // Both registers, one after the other on back-to-back cycles, while the block is idle.
    task automatic set_config(input logic [31:0] lba, input logic [7:0] spc_val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= fat12ccw_pkg::CFG_DATA_START;
        i_cfg_data  <= lba;
        @(posedge i_clk);
        data_start = lba;
        i_cfg_index <= fat12ccw_pkg::CFG_SPC;
        i_cfg_data  <= {24'd0, spc_val};
        @(posedge i_clk);
        spc = spc_val;
        i_cfg_we <= 1'b0;
    endtask

    // One configuration setting with a mix of chain builds, repeat walks,
    // bad starts and stray loads.
    task automatic run_phase(input int idle_pct, input logic [31:0] lba,
                             input logic [7:0] spc_val);
        int          goal;
        int          sel;
        logic [11:0] clus;
        drain_results(8);
        set_config(lba, spc_val);
        sender_idle_pct = idle_pct;
        goal = beats_sent + PHASE_BEATS;
        while (beats_sent < goal) begin
            sel = $urandom_range(99);
            if (sel < 50) begin
                build_and_walk();
            end else if (sel < 65 && chain_heads.size() != 0) begin
                clus = chain_heads[$urandom_range(chain_heads.size() - 1)];
                if (walk_is_defined(clus)) send_beat(walk_beat(clus), 1'b0, '0);
                else send_noise();
            end else if (sel < 75) begin
                send_beat(walk_beat(12'($urandom_range(1))), 1'b0, '0);
            end else if (sel < 88) begin
                send_noise();
            end else begin
                clus = 12'($urandom);
                if (walk_is_defined(clus)) send_beat(walk_beat(clus), 1'b0, '0);
                else send_noise();
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Every strobed result is matched against the oldest expectation.
    always @(posedge i_clk) begin
        fat12ccw_pkg::t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: result with none expected, expected none, actual %h",
                         $time, o_result);
            end else begin
                want = pending_results.pop_front();
                check_field("cluster", 32'(want.cluster), 32'(o_result.cluster));
                check_field("sector_address", want.sector_address, o_result.sector_address);
                check_field("status", 32'(want.status), 32'(o_result.status));
                check_field("last", 32'(want.last), 32'(o_result.last));
            end
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_item      <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        error_count     = 0;
        beats_sent      = 0;
        sender_idle_pct = 34;
        data_start      = 32'd33;
        spc             = 8'd1;
        foreach (fat_image[a]) begin
            fat_image[a]  = 8'h00;
            fat_loaded[a] = 1'b0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats under the reset configuration. Entry 2 ends at once,
        // 3 -> 4 -> 0xFF0 -> 1 runs through a reserved value into a bad cluster,
        // 4095 is the top cluster, and 5 points at itself until truncation.
        dir_rows = '{
            dir_load(3, 8'hFF),
            dir_load(4, 8'h4F),
            dir_walk_exp(12'd2, 32'd33, fat12ccw_pkg::ST_OK),
            dir_walk_exp(12'd0, 32'd0, fat12ccw_pkg::ST_BAD),
            dir_walk_exp(12'd1, 32'd0, fat12ccw_pkg::ST_BAD),
            dir_load(5, 8'h00),
            dir_load(6, 8'hF0),
            dir_load(7, 8'h5F),
            dir_load(8, 8'h00),
            dir_load(6120, 8'h01),
            dir_load(6121, 8'h00),
            dir_walk(12'd3),
            dir_walk(12'd4),
            dir_load(6142, 8'h80),
            dir_load(6143, 8'hFF),
            dir_walk_exp(12'd4095, 32'd4126, fat12ccw_pkg::ST_OK),
            dir_walk(12'd5),
            dir_load(8191, 8'hA5),
            dir_load(0, 8'h00)
        };
        foreach (dir_rows[r]) send_beat(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);

        // Random phases: sender idling at 34%, then 64%, then not at all.
        run_phase(34, 32'd0, 8'd1);
        run_phase(34, 32'hFFFF_FFFF, 8'd128);
        run_phase(64, $urandom, 8'd0);
        run_phase(64, $urandom, 8'd255);
        run_phase(0, $urandom, 8'($urandom_range(1, 128)));
        run_phase(0, $urandom, 8'($urandom_range(1, 128)));

        drain_results(WALK_LATENCY);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog that fails the run if the test above never reaches its end.
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
